[rtl/tmq_pkg.sv]
// ----------------------------------------------------------------------------
// tmq_pkg
// Shared types and constants for the typed message queue: the word formats
// of both channels, the slot contents held in each cell, and the status codes.
// ----------------------------------------------------------------------------
`default_nettype none

package tmq_pkg;

    localparam int SLOTS = 16;
    localparam int CNT_W = $clog2(SLOTS + 1);

    localparam int TYPE_W  = 32;
    localparam int LEN_W   = 16;
    localparam int REF_W   = 32;
    localparam int QCNT_W  = 5;

    localparam logic [LEN_W-1:0] RESET_BYTE_LIMIT = 16'd4096;

    typedef enum logic {
        CMD_SEND = 1'b0,
        CMD_RECV = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_NOMATCH = 2'd2,
        ST_TOOBIG  = 2'd3
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } t_state;

    typedef struct packed {
        t_cmd                     command;
        logic signed [TYPE_W-1:0] msg_type;
        logic [LEN_W-1:0]         msg_len;
        logic [REF_W-1:0]         payload_ref;
        logic                     truncate_ok;
    } t_in_item;

    typedef struct packed {
        t_status                  status;
        logic signed [TYPE_W-1:0] out_type;
        logic [LEN_W-1:0]         out_len;
        logic [REF_W-1:0]         out_payload_ref;
        logic [QCNT_W-1:0]        queued_count;
    } t_out_item;

    typedef struct packed {
        logic signed [TYPE_W-1:0] msg_type;
        logic [LEN_W-1:0]         msg_len;
        logic [REF_W-1:0]         payload_ref;
    } t_slot;

    // Per-cell control from the queue controller.
    typedef struct packed {
        logic load_en;
        logic shift_en;
    } t_cell_ctl;

endpackage

`default_nettype wire

[rtl/typed_message_queue_core.sv]
// ----------------------------------------------------------------------------
// typed_message_queue_core
// Ordered mailbox of typed messages with a byte budget, built as a row of
// slot cells kept packed with the oldest message in cell 0.
//
//   channel | direction | handshake               | word
//   --------+-----------+-------------------------+-----------------
//   in      | input     | i_in_valid / o_in_stall | i_in_item
//   out     | output    | o_out_valid / i_out_stall | o_out_item
//   cfg     | input     | i_cfg_we                | i_cfg_wdata
//
// Each word is first registered; then, in the execute state, every cell
// matches in parallel, the first-match chain picks the oldest hit, and the
// cells compact or append. A finished result waits in the output register
// while the next word is taken; execution waits only while that register is
// still full and stalled. Reset is synchronous and clears all slot valid bits,
// the byte and message counts, and sets the byte limit to 4096.
// ----------------------------------------------------------------------------
`default_nettype none

module typed_message_queue_core (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_in_valid,
    output logic                         o_in_stall,
    input  wire tmq_pkg::t_in_item       i_in_item,
    output logic                         o_out_valid,
    input  wire logic                    i_out_stall,
    output tmq_pkg::t_out_item           o_out_item,
    input  wire logic                    i_cfg_we,
    input  wire logic [tmq_pkg::LEN_W-1:0] i_cfg_wdata
);
    import tmq_pkg::*;

    t_state             r_state, n_state;
    t_in_item           r_item;
    t_out_item          r_out, n_out;
    logic               r_out_valid, n_out_valid;
    logic [LEN_W-1:0]   r_byte_limit;
    logic [LEN_W-1:0]   r_bytes_used, n_bytes_used;
    logic [CNT_W-1:0]   r_count, n_count;

    logic               w_accept;
    logic               w_exec;

    t_slot              w_slot  [SLOTS];
    logic [SLOTS-1:0]   w_valid;
    logic [SLOTS:0]     w_found;
    logic [SLOTS-1:0]   w_first;
    t_cell_ctl          w_ctl   [SLOTS];
    t_slot              w_load;

    t_slot              w_sel_slot;
    logic               w_any;
    logic               w_len_ok;
    logic               w_remove;
    logic               w_fits;
    logic               w_send_ok;

    // ------------------------------------------------------------------
    // Control
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall = (r_state != S_IDLE);
        w_exec     = (r_state == S_EXEC) && (!r_out_valid || !i_out_stall);
    end

    assign w_accept = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item <= i_in_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_limit <= RESET_BYTE_LIMIT;
        end else if (i_cfg_we) begin
            r_byte_limit <= i_cfg_wdata;
        end
    end

    // ------------------------------------------------------------------
    // Cell row
    // ------------------------------------------------------------------
    assign w_load.msg_type    = r_item.msg_type;
    assign w_load.msg_len     = r_item.msg_len;
    assign w_load.payload_ref = r_item.payload_ref;

    assign w_found[0] = 1'b0;

    for (genvar j = 0; j < SLOTS; j++) begin : g_cell
        t_slot w_next;
        logic  w_next_valid;

        if (j == SLOTS - 1) begin : g_last
            assign w_next       = '0;
            assign w_next_valid = 1'b0;
        end else begin : g_mid
            assign w_next       = w_slot[j+1];
            assign w_next_valid = w_valid[j+1];
        end

        // Every cell at or past the removed one takes its neighbor's message.
        assign w_ctl[j].shift_en = w_exec && w_remove && w_found[j+1];
        assign w_ctl[j].load_en  = w_exec && w_send_ok && (r_count == CNT_W'(j));
        assign w_first[j]        = w_found[j+1] && !w_found[j];

        tmq_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (w_ctl[j]),
            .i_load       (w_load),
            .i_next       (w_next),
            .i_next_valid (w_next_valid),
            .i_sel        (r_item.msg_type),
            .i_found_in   (w_found[j]),
            .o_slot       (w_slot[j]),
            .o_valid      (w_valid[j]),
            .o_found_out  (w_found[j+1])
        );
    end

    always_comb begin
        w_sel_slot = '0;
        for (int k = 0; k < SLOTS; k++) begin
            w_sel_slot = w_sel_slot | (w_slot[k] & {$bits(t_slot){w_first[k]}});
        end
    end

    // ------------------------------------------------------------------
    // Step result
    // ------------------------------------------------------------------
    assign w_any     = w_found[SLOTS];
    assign w_len_ok  = (w_sel_slot.msg_len <= r_item.msg_len) || r_item.truncate_ok;
    assign w_remove  = (r_item.command == CMD_RECV) && w_any && w_len_ok;
    assign w_fits    = (r_bytes_used <= r_byte_limit) &&
                       (r_item.msg_len <= (r_byte_limit - r_bytes_used));
    assign w_send_ok = (r_item.command == CMD_SEND) && w_fits &&
                       (r_count < CNT_W'(SLOTS));

    always_comb begin
        n_count      = r_count;
        n_bytes_used = r_bytes_used;
        n_out        = '0;
        if (r_item.command == CMD_SEND) begin
            if (w_send_ok) begin
                n_count      = r_count + 1'b1;
                n_bytes_used = r_bytes_used + r_item.msg_len;
                n_out.status = ST_OK;
            end else begin
                n_out.status = ST_FULL;
            end
        end else if (!w_any) begin
            n_out.status = ST_NOMATCH;
        end else if (!w_len_ok) begin
            n_out.status = ST_TOOBIG;
        end else begin
            n_count               = r_count - 1'b1;
            n_bytes_used          = r_bytes_used - w_sel_slot.msg_len;
            n_out.status          = ST_OK;
            n_out.out_type        = w_sel_slot.msg_type;
            n_out.out_len         = (w_sel_slot.msg_len <= r_item.msg_len) ?
                                    w_sel_slot.msg_len : r_item.msg_len;
            n_out.out_payload_ref = w_sel_slot.payload_ref;
        end
        n_out.queued_count = QCNT_W'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_bytes_used <= '0;
        end else if (w_exec) begin
            r_count      <= n_count;
            r_bytes_used <= n_bytes_used;
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_comb begin
        n_out_valid = r_out_valid && i_out_stall;
        if (w_exec) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_exec) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(SLOTS))
        else $error("message count above slot count");

    a_valid_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_valid) == 32'(r_count))
        else $error("occupied cells disagree with message count");

    a_valid_packed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((w_valid + 1'b1) & w_valid) == '0)
        else $error("occupied cells are not packed at the head");

    a_first_unique: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_first))
        else $error("more than one first match");

    a_exec_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_exec |=> o_out_valid)
        else $error("executed word produced no result");

endmodule

`default_nettype wire

[rtl/tmq_cell.sv]
// ----------------------------------------------------------------------------
// tmq_cell
// One queue slot: holds a message, matches it against the receive selector,
// and takes its right neighbor's message when the queue compacts.
// ----------------------------------------------------------------------------
`default_nettype none

module tmq_cell (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire tmq_pkg::t_cell_ctl               i_ctl,
    input  wire tmq_pkg::t_slot                   i_load,
    input  wire tmq_pkg::t_slot                   i_next,
    input  wire logic                             i_next_valid,
    input  wire logic signed [tmq_pkg::TYPE_W-1:0] i_sel,
    input  wire logic                             i_found_in,
    output tmq_pkg::t_slot                        o_slot,
    output logic                                  o_valid,
    output logic                                  o_found_out
);
    import tmq_pkg::*;

    t_slot r_slot;
    logic  r_valid;

    logic signed [TYPE_W:0] w_mag;
    logic signed [TYPE_W:0] w_typ;
    logic                   w_type_ok;
    logic                   w_match;

    // Negative selector: any type not above its magnitude. One extra bit keeps
    // the magnitude of the most negative selector exact.
    assign w_mag = -{i_sel[TYPE_W-1], i_sel};
    assign w_typ = {r_slot.msg_type[TYPE_W-1], r_slot.msg_type};

    always_comb begin
        if (i_sel == '0) begin
            w_type_ok = 1'b1;
        end else if (!i_sel[TYPE_W-1]) begin
            w_type_ok = (r_slot.msg_type == i_sel);
        end else begin
            w_type_ok = (w_typ <= w_mag);
        end
    end

    assign w_match     = r_valid && w_type_ok;
    assign o_found_out = i_found_in || w_match;
    assign o_slot      = r_slot;
    assign o_valid     = r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.shift_en) begin
            r_valid <= i_next_valid;
        end else if (i_ctl.load_en) begin
            r_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift_en) begin
            r_slot <= i_next;
        end else if (i_ctl.load_en) begin
            r_slot <= i_load;
        end
    end

endmodule

`default_nettype wire
